// ===== hdl/htcs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package htcs_pkg;
    localparam int LEVELS_DEF     = 256;
    localparam int COUNT_BITS_DEF = 20;
    localparam int LEVEL_BITS     = 8;
    localparam int THR_BITS       = 20;
    localparam logic [THR_BITS-1:0] THR_RESET = 20'd50;
    localparam logic [7:0] LEVEL_MAX = 8'd255;
    // Quotient bits and numerator width for 510*(i-lo)/(2*(hi-lo)+1)
    localparam int QUO_BITS = 8;
    localparam int NUM_BITS = 17;
    localparam int DEN_BITS = 9;

    localparam logic OP_ACCUM = 1'b0;
    localparam logic OP_MAP   = 1'b1;
    localparam logic KIND_MAP    = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ACC_RD,
        ST_ACC_WR,
        ST_MAP_RD,
        ST_MAP_OUT,
        ST_SCAN_RD,
        ST_SCAN,
        ST_DIV_SETUP,
        ST_DIV,
        ST_WRITE,
        ST_REPORT
    } state_t;

    typedef struct packed {
        logic start;
        logic [NUM_BITS-1:0] num;
        logic [DEN_BITS-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic done;
        logic [QUO_BITS-1:0] quo;
    } div_rsp_t;
endpackage
`default_nettype wire

// ===== hdl/htcs_divider.sv =====
`timescale 1ns / 1ps
`default_nettype none
module htcs_divider
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire htcs_pkg::div_req_t req,
    output htcs_pkg::div_rsp_t      rsp
);
    import htcs_pkg::*;

    // Restoring division, one quotient bit per cycle; quotient fits 8 bits.
    logic [NUM_BITS-1:0] rem_reg, rem_next;
    logic [QUO_BITS-1:0] quo_reg, quo_next;
    logic [DEN_BITS-1:0] den_reg, den_next;
    logic [3:0]          cnt_reg, cnt_next;
    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [NUM_BITS-1:0] shifted;
    logic [NUM_BITS-1:0] trial;
    logic [NUM_BITS:0]   diff;

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted   = '0;
        trial     = '0;
        diff      = '0;
        if (req.start)
        begin
            rem_next  = req.num;
            den_next  = req.den;
            quo_next  = '0;
            cnt_next  = 4'(QUO_BITS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // Compare remainder against den << (cnt-1)
            trial = NUM_BITS'(den_reg) << (cnt_reg - 4'd1);
            diff  = {1'b0, rem_reg} - {1'b0, trial};
            shifted = rem_reg;
            if (!diff[NUM_BITS])
            begin
                rem_next = diff[NUM_BITS-1:0];
                quo_next = {quo_reg[QUO_BITS-2:0], 1'b1};
            end
            else
            begin
                quo_next = {quo_reg[QUO_BITS-2:0], 1'b0};
                rem_next = shifted;
            end
            cnt_next = cnt_reg - 4'd1;
            if (cnt_reg == 4'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;
endmodule
`default_nettype wire

// ===== hdl/histogram_threshold_contrast_stretch.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Channel    | Handshake               | Payload
// -----------+-------------------------+------------------------------------------
// command    | start, busy             | op, pixel, frame_last
// result     | result_valid (strobe)   | result_kind, mapped_pixel, low_level,
//            |                         | high_level, any_level_found
// config     | cfg_valid, cfg_ready    | cfg_data (count_threshold)
//
// An accumulate holds busy through a histogram read, then a saturating add and write;
// a map holds busy through a table read, then the result strobes as busy drops.
// A frame end adds a scan of every level (read, then compare), then per level a setup,
// an 8-bit division for the levels from low to high, and a table write.
// Reset clears control state and the histogram valid bits and sets the threshold to 50.
// The result strobe lasts one cycle; the receiver cannot stall it.
module histogram_threshold_contrast_stretch
#(
    parameter int LEVELS     = htcs_pkg::LEVELS_DEF,
    parameter int COUNT_BITS = htcs_pkg::COUNT_BITS_DEF
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic                          op,
    input  wire logic [htcs_pkg::LEVEL_BITS-1:0] pixel,
    input  wire logic                          frame_last,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [htcs_pkg::THR_BITS-1:0] cfg_data,
    output logic                               result_valid,
    output logic                               result_kind,
    output logic [htcs_pkg::LEVEL_BITS-1:0]    mapped_pixel,
    output logic [htcs_pkg::LEVEL_BITS-1:0]    low_level,
    output logic [htcs_pkg::LEVEL_BITS-1:0]    high_level,
    output logic                               any_level_found
);
    import htcs_pkg::*;

    localparam int IDX_BITS = $clog2(LEVELS);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    state_t state_reg, state_next;

    // Histogram memory with per-bin valid bits standing in for the zero reset
    logic [COUNT_BITS-1:0] hist_mem [LEVELS];
    logic [LEVELS-1:0]     hist_vld_reg;
    logic [COUNT_BITS-1:0] hist_rd_reg;
    logic                  hist_rd_vld_reg;
    logic [7:0]            tbl_mem [LEVELS];
    logic [7:0]            tbl_rd_reg;

    logic [THR_BITS-1:0]   thr_reg;
    logic                  table_ready_reg;
    logic [IDX_BITS-1:0]   pix_reg;
    logic                  last_reg;
    logic [IDX_BITS-1:0]   idx_reg, idx_next;
    logic [IDX_BITS-1:0]   lo_reg, lo_next, hi_reg, hi_next;
    logic                  found_reg, found_next;
    logic [7:0]            val_reg, val_next;

    logic [COUNT_BITS-1:0] count_eff;
    logic                  occupied;
    logic                  idx_last;
    div_req_t              dreq;
    div_rsp_t              drsp;

    logic                  rd_en, acc_wr, tbl_wr, tbl_rd;
    logic [IDX_BITS-1:0]   rd_addr;

    assign count_eff = hist_rd_vld_reg ? hist_rd_reg : '0;
    assign occupied  = (THR_BITS > COUNT_BITS)
                       ? ({{(THR_BITS+COUNT_BITS){1'b0}}, count_eff} >
                          {{(COUNT_BITS+COUNT_BITS){1'b0}}, thr_reg})
                       : ({{THR_BITS{1'b0}}, count_eff} >
                          {{COUNT_BITS{1'b0}}, thr_reg});
    assign idx_last  = (idx_reg == IDX_BITS'(LEVELS - 1));

    htcs_divider u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .rsp   (drsp)
    );

    // Next-state logic
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                    state_next = (op == OP_MAP) ? ST_MAP_RD : ST_ACC_RD;
            end
            ST_ACC_RD:    state_next = ST_ACC_WR;
            ST_ACC_WR:    state_next = last_reg ? ST_SCAN_RD : ST_IDLE;
            ST_MAP_RD:    state_next = ST_MAP_OUT;
            ST_MAP_OUT:   state_next = ST_IDLE;
            ST_SCAN_RD:   state_next = ST_SCAN;
            ST_SCAN:      state_next = idx_last ? ST_DIV_SETUP : ST_SCAN_RD;
            ST_DIV_SETUP:
            begin
                if (found_reg && idx_reg >= lo_reg && idx_reg <= hi_reg)
                    state_next = ST_DIV;
                else
                    state_next = ST_WRITE;
            end
            ST_DIV:       state_next = drsp.done ? ST_WRITE : ST_DIV;
            ST_WRITE:     state_next = idx_last ? ST_REPORT : ST_DIV_SETUP;
            ST_REPORT:    state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // Output and datapath control
    always_comb
    begin
        idx_next   = idx_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        found_next = found_reg;
        val_next   = val_reg;
        rd_en      = 1'b0;
        rd_addr    = pix_reg;
        acc_wr     = 1'b0;
        tbl_wr     = 1'b0;
        tbl_rd     = 1'b0;
        dreq.start = 1'b0;
        dreq.num   = NUM_BITS'(17'd510 * 17'(idx_reg - lo_reg));
        dreq.den   = DEN_BITS'({1'b0, 8'(hi_reg - lo_reg), 1'b1});
        unique case (state_reg)
            ST_ACC_RD:
            begin
                rd_en = 1'b1;
                idx_next   = '0;
                found_next = 1'b0;
                lo_next    = '0;
                hi_next    = '0;
            end
            ST_ACC_WR:    acc_wr = 1'b1;
            ST_MAP_RD:    tbl_rd = 1'b1;
            ST_SCAN_RD:
            begin
                rd_en   = 1'b1;
                rd_addr = idx_reg;
            end
            ST_SCAN:
            begin
                if (occupied)
                begin
                    if (!found_reg)
                        lo_next = idx_reg;
                    hi_next    = idx_reg;
                    found_next = 1'b1;
                end
                idx_next = idx_reg + 1'b1;
            end
            ST_DIV_SETUP:
            begin
                if (!found_reg || idx_reg < lo_reg)
                    val_next = '0;
                else if (idx_reg > hi_reg)
                    val_next = LEVEL_MAX;
                else
                    dreq.start = 1'b1;
            end
            ST_DIV:
            begin
                if (drsp.done)
                    val_next = drsp.quo;
            end
            ST_WRITE:
            begin
                tbl_wr   = 1'b1;
                idx_next = idx_reg + 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = (state_reg == ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            thr_reg         <= THR_RESET;
            table_ready_reg <= 1'b0;
            hist_vld_reg    <= '0;
            idx_reg         <= '0;
            found_reg       <= 1'b0;
            lo_reg          <= '0;
            hi_reg          <= '0;
            result_valid    <= 1'b0;
            result_kind     <= KIND_MAP;
            mapped_pixel    <= '0;
            low_level       <= '0;
            high_level      <= '0;
            any_level_found <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            idx_reg      <= idx_next;
            found_reg    <= found_next;
            lo_reg       <= lo_next;
            hi_reg       <= hi_next;
            result_valid <= 1'b0;
            if (cfg_valid && cfg_ready)
                thr_reg <= cfg_data;
            if (acc_wr)
                hist_vld_reg[pix_reg] <= 1'b1;
            // Drop each bin as the build writes its table entry
            if (tbl_wr)
                hist_vld_reg[idx_reg] <= 1'b0;
            if (state_reg == ST_MAP_OUT)
            begin
                result_valid    <= 1'b1;
                result_kind     <= KIND_MAP;
                mapped_pixel    <= table_ready_reg ? tbl_rd_reg : 8'(pix_reg);
                low_level       <= '0;
                high_level      <= '0;
                any_level_found <= 1'b0;
            end
            if (state_reg == ST_REPORT)
            begin
                table_ready_reg <= 1'b1;
                result_valid    <= 1'b1;
                result_kind     <= KIND_REPORT;
                mapped_pixel    <= '0;
                low_level       <= found_reg ? 8'(lo_reg) : '0;
                high_level      <= found_reg ? 8'(hi_reg) : '0;
                any_level_found <= found_reg;
            end
        end
    end

    // Hold the command fields for the duration of the transaction
    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            pix_reg  <= IDX_BITS'(pixel);
            last_reg <= frame_last;
        end
        val_reg <= val_next;
        if (rd_en)
        begin
            hist_rd_reg     <= hist_mem[rd_addr];
            hist_rd_vld_reg <= hist_vld_reg[rd_addr];
        end
        if (acc_wr)
            hist_mem[pix_reg] <= (count_eff == COUNT_MAX) ? COUNT_MAX
                                 : count_eff + 1'b1;
        if (tbl_rd)
            tbl_rd_reg <= tbl_mem[pix_reg];
        if (tbl_wr)
            tbl_mem[idx_reg] <= val_reg;
    end
endmodule
`default_nettype wire

// ===== dv/histogram_threshold_contrast_stretch_checker.sv =====
`timescale 1ns / 1ps
module histogram_threshold_contrast_stretch_checker
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic                            busy,
    input  logic                            op,
    input  logic [htcs_pkg::LEVEL_BITS-1:0] pixel,
    input  logic                            frame_last,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [htcs_pkg::THR_BITS-1:0]   cfg_data,
    input  logic                            result_valid,
    input  logic                            result_kind,
    input  logic [htcs_pkg::LEVEL_BITS-1:0] mapped_pixel,
    input  logic [htcs_pkg::LEVEL_BITS-1:0] low_level,
    input  logic [htcs_pkg::LEVEL_BITS-1:0] high_level,
    input  logic                            any_level_found,
    output int                              fail_count,
    output int                              pending_count,
    output int                              map_seen,
    output int                              report_seen
);
    import htcs_pkg::*;

    typedef struct packed {
        logic       kind;
        logic [7:0] mapped;
        logic [7:0] lo;
        logic [7:0] hi;
        logic       found;
    } stretch_result_t;

    localparam logic [COUNT_BITS_DEF-1:0] COUNT_SAT = '1;

    logic [COUNT_BITS_DEF-1:0] bin_count [LEVELS_DEF];
    logic [7:0]                lut [LEVELS_DEF];
    logic                      lut_valid;
    logic [THR_BITS-1:0]       threshold;
    stretch_result_t           expected_results[$];

    // Scan the histogram, rebuild the lookup table, clear the bins.
    function automatic stretch_result_t build_stretch();
        stretch_result_t r;
        int lo;
        int hi;
        lo = -1;
        hi = -1;
        for (int i = 0; i < LEVELS_DEF; i++)
            if (bin_count[i] > threshold) begin
                if (lo < 0) lo = i;
                hi = i;
            end
        for (int i = 0; i < LEVELS_DEF; i++) begin
            if (lo < 0 || i < lo) lut[i] = 8'd0;
            else if (i > hi) lut[i] = LEVEL_MAX;
            else lut[i] = 8'((510 * (i - lo)) / (2 * (hi - lo) + 1));
            bin_count[i] = '0;
        end
        lut_valid = 1'b1;
        r = '0;
        r.kind = KIND_REPORT;
        if (lo >= 0) begin
            r.lo = 8'(lo);
            r.hi = 8'(hi);
            r.found = 1'b1;
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        stretch_result_t e;
        stretch_result_t got;
        if (!rst_n) begin
            for (int i = 0; i < LEVELS_DEF; i++) begin
                bin_count[i] = '0;
                lut[i] = 8'd0;
            end
            lut_valid = 1'b0;
            threshold = THR_RESET;
            expected_results.delete();
            fail_count = 0;
            map_seen = 0;
            report_seen = 0;
        end else begin
            if (result_valid) begin
                got = {result_kind, mapped_pixel, low_level, high_level, any_level_found};
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %h", $time, got);
                    fail_count++;
                end else begin
                    e = expected_results.pop_front();
                    if (got.kind !== e.kind || got.mapped !== e.mapped || got.lo !== e.lo ||
                        got.hi !== e.hi || got.found !== e.found) begin
                        $display("%0t: mismatch expected kind=%b map=%0d lo=%0d hi=%0d found=%b",
                                 $time, e.kind, e.mapped, e.lo, e.hi, e.found);
                        $display("%0t:            actual kind=%b map=%0d lo=%0d hi=%0d found=%b",
                                 $time, got.kind, got.mapped, got.lo, got.hi, got.found);
                        fail_count++;
                    end
                    if (e.kind == KIND_REPORT) report_seen++;
                    else map_seen++;
                end
            end
            if (cfg_valid && cfg_ready) threshold = cfg_data;
            if (start && !busy) begin
                if (op == OP_MAP) begin
                    e = '0;
                    e.kind = KIND_MAP;
                    e.mapped = lut_valid ? lut[pixel] : pixel;
                    expected_results.push_back(e);
                end else begin
                    if (bin_count[pixel] != COUNT_SAT) bin_count[pixel]++;
                    if (frame_last) expected_results.push_back(build_stretch());
                end
            end
        end
        pending_count = expected_results.size();
    end
endmodule

// ===== dv/histogram_threshold_contrast_stretch_test.sv =====
`timescale 1ns / 1ps
module histogram_threshold_contrast_stretch_test;
    import htcs_pkg::*;

    // Frame ends rebuild the whole table; allow a wide margin for them.
    localparam int CYCLE_LIMIT = 4000000;
    localparam int DRAIN_CYCLES = 40;

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    logic                  op;
    logic [LEVEL_BITS-1:0] pixel;
    logic                  frame_last;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [THR_BITS-1:0]   cfg_data;
    logic                  result_valid;
    logic                  result_kind;
    logic [LEVEL_BITS-1:0] mapped_pixel;
    logic [LEVEL_BITS-1:0] low_level;
    logic [LEVEL_BITS-1:0] high_level;
    logic                  any_level_found;
    int                    fail_count;
    int                    pending_count;
    int                    map_seen;
    int                    report_seen;
    int                    cycle_count;
    int                    burst_left;
    int                    item_count;

    histogram_threshold_contrast_stretch u_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .op(op), .pixel(pixel),
        .frame_last(frame_last), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_data(cfg_data), .result_valid(result_valid), .result_kind(result_kind),
        .mapped_pixel(mapped_pixel), .low_level(low_level), .high_level(high_level),
        .any_level_found(any_level_found)
    );

    histogram_threshold_contrast_stretch_checker u_checker (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .op(op), .pixel(pixel),
        .frame_last(frame_last), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_data(cfg_data), .result_valid(result_valid), .result_kind(result_kind),
        .mapped_pixel(mapped_pixel), .low_level(low_level), .high_level(high_level),
        .any_level_found(any_level_found), .fail_count(fail_count),
        .pending_count(pending_count), .map_seen(map_seen), .report_seen(report_seen)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Watchdog: end the run if the block hangs.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("histogram_threshold_contrast_stretch_test: FAIL");
            $finish;
        end
    end

    // Send one command transaction; hold start until the block takes it.
    // Gaps come in bursts: a new burst may open with a random gap, none inside.
    task automatic send_pixel(input logic o, input logic [7:0] p, input logic l);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 3) != 0) begin
                start <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
        end
        burst_left--;
        start <= 1'b1;
        op <= o;
        pixel <= p;
        frame_last <= l;
        @(posedge clk);
        while (busy) @(posedge clk);
        item_count++;
    endtask

    // Write the threshold while idle: drain results, then wait out the tail.
    task automatic write_threshold(input logic [THR_BITS-1:0] value);
        start <= 1'b0;
        @(posedge clk);
        while (pending_count != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Fill one frame with npix pixels, mostly spread over a random band, plus a closing
    // pixel, then map nmap pixels through the new table.
    task automatic run_frame(input int npix, input int nmap);
        int base;
        int span;
        base = $urandom_range(0, 255);
        span = $urandom_range(0, 255);
        for (int k = 0; k < npix; k++) begin
            if ($urandom_range(0, 9) == 0)
                send_pixel(OP_ACCUM, 8'($urandom), 1'b0);
            else
                send_pixel(OP_ACCUM, 8'(base + $urandom_range(0, span)), 1'b0);
        end
        send_pixel(OP_ACCUM, 8'($urandom), 1'b1);
        for (int k = 0; k < nmap; k++)
            send_pixel(OP_MAP, 8'($urandom), 1'($urandom));
    endtask

    initial begin
        rst_n = 1'b0;
        start = 1'b0;
        op = OP_ACCUM;
        pixel = '0;
        frame_last = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        cycle_count = 0;
        burst_left = 0;
        item_count = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Map before any table exists: pixels pass through unchanged.
        send_pixel(OP_MAP, 8'd0, 1'b0);
        send_pixel(OP_MAP, 8'd255, 1'b1);
        send_pixel(OP_MAP, 8'hA5, 1'b0);
        // Frame with no occupied bin at the reset threshold: all-zero table.
        send_pixel(OP_ACCUM, 8'd0, 1'b0);
        send_pixel(OP_ACCUM, 8'd255, 1'b1);
        send_pixel(OP_MAP, 8'd255, 1'b0);
        send_pixel(OP_MAP, 8'h5A, 1'b0);

        // Threshold zero: occupied bins at both extremes, full-range stretch.
        write_threshold('0);
        send_pixel(OP_ACCUM, 8'd0, 1'b0);
        send_pixel(OP_ACCUM, 8'd255, 1'b1);
        send_pixel(OP_MAP, 8'd0, 1'b0);
        send_pixel(OP_MAP, 8'd128, 1'b0);
        send_pixel(OP_MAP, 8'd255, 1'b0);
        // Single occupied level: lo equals hi.
        send_pixel(OP_ACCUM, 8'd77, 1'b1);
        send_pixel(OP_MAP, 8'd76, 1'b0);
        send_pixel(OP_MAP, 8'd77, 1'b0);
        send_pixel(OP_MAP, 8'd78, 1'b0);

        // Maximum threshold: nothing is ever occupied.
        write_threshold('1);
        run_frame(8, 3);

        // Random phases over a range of thresholds, small ones mostly.
        while (item_count < 1850) begin
            case ($urandom_range(0, 3))
                0: write_threshold(THR_BITS'($urandom_range(0, 3)));
                1: write_threshold(THR_BITS'($urandom_range(0, 12)));
                2: write_threshold(THR_RESET);
                default: write_threshold(THR_BITS'($urandom));
            endcase
            repeat ($urandom_range(1, 4)) begin
                if ($urandom_range(0, 7) == 0) begin
                    // Stray maps between frames.
                    repeat ($urandom_range(1, 8))
                        send_pixel(OP_MAP, 8'($urandom), 1'($urandom));
                end
                run_frame($urandom_range(5, 120), $urandom_range(4, 40));
            end
        end

        // Threshold at the ceiling minus one: saturating one bin would take too long
        // at 20 bits, so this frame only checks that no bin is occupied.
        write_threshold(20'hFFFFE);
        run_frame(4, 2);

        start <= 1'b0;
        @(posedge clk);
        while (pending_count != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d command transactions: %0d mapped pixels, %0d frame reports.",
                 item_count, map_seen, report_seen);
        if (fail_count == 0)
            $display("histogram_threshold_contrast_stretch_test: PASS");
        else
            $display("histogram_threshold_contrast_stretch_test: FAIL");
        $finish;
    end
endmodule

// ===== files.f =====
hdl/htcs_pkg.sv
hdl/htcs_divider.sv
hdl/histogram_threshold_contrast_stretch.sv
dv/histogram_threshold_contrast_stretch_checker.sv
dv/histogram_threshold_contrast_stretch_test.sv
